// ===== hw/rtl/pbl_pkg.sv =====
`timescale 1ns / 1ps
package pbl_pkg;

   localparam int SCREEN_WIDTH        = 128;
   localparam int SCREEN_HEIGHT_DEF   = 64;
   localparam int PAGE_COUNT_DEF      = 8;

   localparam int BAND_COLS   = 128;
   localparam int COLS_PER_ROW = 4;
   localparam int BAND_ROWS   = BAND_COLS / COLS_PER_ROW;
   localparam int ROW_W       = $clog2(BAND_ROWS);
   localparam int LANE_W      = $clog2(COLS_PER_ROW);
   localparam int ROW_BITS    = 8 * COLS_PER_ROW;
   localparam int BIT_IDX_W   = $clog2(ROW_BITS);

   localparam int IN_COORD_W  = 12;
   localparam int COORD_W     = IN_COORD_W + 1;
   localparam int ERR_W       = COORD_W + 1;
   localparam int PAGE_CNT_W  = 4;
   localparam int PAGE_NUM_W  = 3;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_PIXEL = 2'd1,
      CMD_LINE  = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_type;

   localparam logic [1:0] COLOR_CLEAR  = 2'd0;
   localparam logic [1:0] COLOR_SET    = 2'd1;
   localparam logic [1:0] COLOR_INVERT = 2'd2;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   typedef struct packed {
      cmd_type                       cmd;
      logic signed [IN_COORD_W-1:0]  x_start;
      logic signed [IN_COORD_W-1:0]  y_start;
      logic signed [IN_COORD_W-1:0]  x_end;
      logic signed [IN_COORD_W-1:0]  y_end;
      logic [1:0]                    color;
   } req_type;

   typedef struct packed {
      logic [PAGE_NUM_W-1:0] page_number;
      logic [ROW_W-1:0]      chunk_index;
      logic [ROW_BITS-1:0]   chunk_bytes;
      logic                  last_chunk;
      logic                  frame_done;
   } rsp_type;

endpackage

// ===== hw/rtl/paged_band_line_plotter_unit.sv =====
`timescale 1ns / 1ps
// Paged band plotter for a 128-column monochrome page-mode display.
// One band of 128 columns by 8 rows is kept in a 32 x 32-bit memory, one
// word per group of four columns. Software draws the whole picture once per
// page; pixels off the current page or off the rotated screen are dropped.
// Input channel (req_): one command per transaction: start frame, plot pixel,
// draw line, flush. req_stall is high while a command is being worked on.
// Result channel (rsp_): a flush returns 32 chunk transactions, chunk 0 first.
// Start frame does not leave idle, so it never stalls the input. A pixel is
// accepted, passes the setup states ST_SETUP_ABS and ST_SETUP_ORDER, then
// ST_PLOT, and adds ST_WRITE if it hits the page; a line takes the same setup,
// then ST_PLOT, plus ST_WRITE on a hit, for each pixel along its major axis.
// ST_PLOT reads the word and ST_WRITE writes it back (registered read data).
// During a flush each chunk is read into the memory read register and then
// loaded into the output register; while rsp_stall is low one chunk follows per
// cycle; a stalled chunk holds in the output register and the memory walk pauses
// until it is taken.
// Reset (synchronous, active high) zeroes the band through per-word valid
// bits at once, sets page 0 and rotation 0; no clearing pass is needed.
// csr_we writes the rotation register; write it only while idle.
module paged_band_line_plotter_unit #(
   parameter int SCREEN_HEIGHT = pbl_pkg::SCREEN_HEIGHT_DEF,
   parameter int PAGE_COUNT    = pbl_pkg::PAGE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pbl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pbl_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_wdata
);
   import pbl_pkg::*;

   localparam logic signed [COORD_W-1:0] ONE_C     = COORD_W'(1);
   localparam logic signed [COORD_W-1:0] MINUS_ONE = -ONE_C;
   localparam logic signed [COORD_W-1:0] WIDTH_C   = COORD_W'(SCREEN_WIDTH);
   localparam logic signed [COORD_W-1:0] HEIGHT_C  = COORD_W'(SCREEN_HEIGHT);
   localparam logic signed [COORD_W-1:0] XMAX_C    = COORD_W'(SCREEN_WIDTH - 1);
   localparam logic signed [COORD_W-1:0] YMAX_C    = COORD_W'(SCREEN_HEIGHT - 1);
   localparam logic [PAGE_CNT_W-1:0]     PAGES_C   = PAGE_CNT_W'(PAGE_COUNT);
   localparam logic [ROW_W-1:0]          LAST_ROW  = ROW_W'(BAND_ROWS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP_ABS,
      ST_SETUP_ORDER,
      ST_PLOT,
      ST_WRITE,
      ST_FLUSH
   } state_type;

   // band memory
   logic [ROW_BITS-1:0] band_mem [BAND_ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;

   state_type state_ff, state_in;
   logic [1:0] rotation_ff, rotation_in;
   logic [PAGE_CNT_W-1:0] page_cnt_ff, page_cnt_in;
   logic [BAND_ROWS-1:0] row_valid_ff, row_valid_in;
   logic rd_valid_ff, rd_valid_in;

   logic signed [COORD_W-1:0] xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [1:0] color_ff, color_in;
   logic [COORD_W-1:0] adx_ff, adx_in, ady_ff, ady_in, dx_ff, dx_in, dy_ff, dy_in;
   logic steep_ff, steep_in, ystep_neg_ff, ystep_neg_in;
   logic signed [COORD_W-1:0] x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic last_ff, last_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic [2:0] bit_row_ff, bit_row_in;
   logic [ROW_W-1:0] addr_ff, addr_in;

   logic [PAGE_NUM_W-1:0] flush_page_ff, flush_page_in;
   logic flush_done_ff, flush_done_in;
   logic [ROW_W-1:0] chunk_ff, chunk_in;

   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // memory port controls
   logic mem_re, mem_we;
   logic [ROW_W-1:0] mem_raddr;
   logic [ROW_BITS-1:0] mem_wdata;
   logic rsp_load;

   // datapath temporaries
   logic signed [COORD_W-1:0] ddx, ddy;
   logic [COORD_W-1:0] dmaj;
   logic signed [COORD_W-1:0] a0, a1, b0, b1;
   logic signed [COORD_W-1:0] plot_x, plot_y, lim_w, lim_h, px_c, py_c;
   logic in_bounds, on_page, hit;
   logic signed [ERR_W-1:0] err_sub;
   logic [ROW_BITS-1:0] word_c, bit_mask;
   logic [BIT_IDX_W-1:0] bit_idx;
   logic [PAGE_CNT_W-1:0] next_page;
   logic accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      rotation_in   = csr_we ? csr_wdata : rotation_ff;
      page_cnt_in   = page_cnt_ff;
      row_valid_in  = row_valid_ff;
      rd_valid_in   = rd_valid_ff;
      xs_in = xs_ff; ys_in = ys_ff; xe_in = xe_ff; ye_in = ye_ff;
      color_in      = color_ff;
      adx_in = adx_ff; ady_in = ady_ff; dx_in = dx_ff; dy_in = dy_ff;
      steep_in      = steep_ff;
      ystep_neg_in  = ystep_neg_ff;
      x0_in = x0_ff; y0_in = y0_ff; x1_in = x1_ff;
      err_in        = err_ff;
      last_in       = last_ff;
      lane_in       = lane_ff;
      bit_row_in    = bit_row_ff;
      addr_in       = addr_ff;
      flush_page_in = flush_page_ff;
      flush_done_in = flush_done_ff;
      chunk_in      = chunk_ff;
      rsp_data_in   = rsp_data_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      mem_raddr     = addr_ff;
      rsp_load      = 1'b0;

      ddx  = xe_ff - xs_ff;
      ddy  = ye_ff - ys_ff;
      dmaj = steep_ff ? ady_ff : adx_ff;
      a0   = steep_ff ? ys_ff : xs_ff;
      b0   = steep_ff ? xs_ff : ys_ff;
      a1   = steep_ff ? ye_ff : xe_ff;
      b1   = steep_ff ? xe_ff : ye_ff;

      // current pixel: clip to the rotated size, then map to the panel
      plot_x = steep_ff ? y0_ff : x0_ff;
      plot_y = steep_ff ? x0_ff : y0_ff;
      lim_w  = rotation_ff[0] ? HEIGHT_C : WIDTH_C;
      lim_h  = rotation_ff[0] ? WIDTH_C : HEIGHT_C;
      in_bounds = (plot_x >= 0) && (plot_x < lim_w) && (plot_y >= 0) && (plot_y < lim_h);
      unique case (rotation_ff)
         ROT_90:  begin px_c = XMAX_C - plot_y; py_c = plot_x;          end
         ROT_180: begin px_c = XMAX_C - plot_x; py_c = YMAX_C - plot_y; end
         ROT_270: begin px_c = plot_y;          py_c = YMAX_C - plot_x; end
         default: begin px_c = plot_x;          py_c = plot_y;          end
      endcase
      on_page = (py_c[COORD_W-1:3] ==
                 {{(COORD_W - 3 - PAGE_CNT_W){1'b0}}, page_cnt_ff});
      hit     = in_bounds && on_page;
      err_sub = err_ff - $signed({1'b0, dy_ff});

      word_c   = rd_valid_ff ? rd_data_ff : '0;
      bit_idx  = {lane_ff, bit_row_ff};
      bit_mask = ROW_BITS'(1) << bit_idx;
      case (color_ff)
         COLOR_CLEAR:  mem_wdata = word_c & ~bit_mask;
         COLOR_SET:    mem_wdata = word_c | bit_mask;
         COLOR_INVERT: mem_wdata = word_c ^ bit_mask;
         default:      mem_wdata = word_c;
      endcase

      next_page = (page_cnt_ff < PAGES_C) ? page_cnt_ff + PAGE_CNT_W'(1) : page_cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               xs_in    = {req_data.x_start[IN_COORD_W-1], req_data.x_start};
               ys_in    = {req_data.y_start[IN_COORD_W-1], req_data.y_start};
               color_in = req_data.color;
               unique case (req_data.cmd)
                  CMD_START: begin
                     page_cnt_in  = '0;
                     row_valid_in = '0;
                  end
                  CMD_PIXEL: begin
                     // a pixel is a line from the point to itself
                     xe_in    = {req_data.x_start[IN_COORD_W-1], req_data.x_start};
                     ye_in    = {req_data.y_start[IN_COORD_W-1], req_data.y_start};
                     state_in = ST_SETUP_ABS;
                  end
                  CMD_LINE: begin
                     xe_in    = {req_data.x_end[IN_COORD_W-1], req_data.x_end};
                     ye_in    = {req_data.y_end[IN_COORD_W-1], req_data.y_end};
                     state_in = ST_SETUP_ABS;
                  end
                  CMD_FLUSH: begin
                     flush_page_in = page_cnt_ff[PAGE_NUM_W-1:0];
                     page_cnt_in   = next_page;
                     flush_done_in = (next_page >= PAGES_C);
                     chunk_in      = '0;
                     addr_in       = '0;
                     mem_re        = 1'b1;
                     mem_raddr     = '0;
                     state_in      = ST_FLUSH;
                  end
                  default: ;
               endcase
            end
         end
         ST_SETUP_ABS: begin
            adx_in   = (ddx < 0) ? COORD_W'(-ddx) : COORD_W'(ddx);
            ady_in   = (ddy < 0) ? COORD_W'(-ddy) : COORD_W'(ddy);
            steep_in = (((ddy < 0) ? -ddy : ddy) > ((ddx < 0) ? -ddx : ddx));
            state_in = ST_SETUP_ORDER;
         end
         ST_SETUP_ORDER: begin
            dx_in  = dmaj;
            dy_in  = steep_ff ? adx_ff : ady_ff;
            err_in = $signed({1'b0, dmaj}) >>> 1;
            if (a0 > a1) begin
               x0_in = a1; y0_in = b1; x1_in = a0;
               ystep_neg_in = !(b1 < b0);
            end else begin
               x0_in = a0; y0_in = b0; x1_in = a1;
               ystep_neg_in = !(b0 < b1);
            end
            state_in = ST_PLOT;
         end
         ST_PLOT: begin
            last_in = (x0_ff == x1_ff);
            x0_in   = x0_ff + ONE_C;
            if (err_sub < 0) begin
               y0_in  = y0_ff + (ystep_neg_ff ? MINUS_ONE : ONE_C);
               err_in = err_sub + $signed({1'b0, dx_ff});
            end else begin
               err_in = err_sub;
            end
            if (hit) begin
               addr_in    = px_c[LANE_W +: ROW_W];
               lane_in    = px_c[LANE_W-1:0];
               bit_row_in = py_c[2:0];
               mem_re     = 1'b1;
               mem_raddr  = px_c[LANE_W +: ROW_W];
               state_in   = ST_WRITE;
            end else if (x0_ff == x1_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_WRITE: begin
            // the read of this word finished last cycle; no other access overlaps
            mem_we                = 1'b1;
            row_valid_in[addr_ff] = 1'b1;
            state_in              = last_ff ? ST_IDLE : ST_PLOT;
         end
         ST_FLUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load                = 1'b1;
               rsp_data_in.page_number = flush_page_ff;
               rsp_data_in.chunk_index = chunk_ff;
               rsp_data_in.chunk_bytes = word_c;
               rsp_data_in.last_chunk  = (chunk_ff == LAST_ROW);
               rsp_data_in.frame_done  = flush_done_ff;
               if (chunk_ff == LAST_ROW) begin
                  if (!flush_done_ff) begin
                     row_valid_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  chunk_in  = chunk_ff + ROW_W'(1);
                  addr_in   = chunk_ff + ROW_W'(1);
                  mem_re    = 1'b1;
                  mem_raddr = chunk_ff + ROW_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (mem_re) begin
         rd_valid_in = row_valid_ff[mem_raddr];
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rotation_ff  <= ROT_0;
         page_cnt_ff  <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rotation_ff  <= rotation_in;
         page_cnt_ff  <= page_cnt_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_valid_ff   <= rd_valid_in;
      xs_ff <= xs_in; ys_ff <= ys_in; xe_ff <= xe_in; ye_ff <= ye_in;
      color_ff      <= color_in;
      adx_ff <= adx_in; ady_ff <= ady_in; dx_ff <= dx_in; dy_ff <= dy_in;
      steep_ff      <= steep_in;
      ystep_neg_ff  <= ystep_neg_in;
      x0_ff <= x0_in; y0_ff <= y0_in; x1_ff <= x1_in;
      err_ff        <= err_in;
      last_ff       <= last_in;
      lane_ff       <= lane_in;
      bit_row_ff    <= bit_row_in;
      addr_ff       <= addr_in;
      flush_page_ff <= flush_page_in;
      flush_done_ff <= flush_done_in;
      chunk_ff      <= chunk_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         band_mem[addr_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= band_mem[mem_raddr];
      end
   end

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("band memory read and write in the same cycle");

   a_rmw_order: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> $past(mem_re))
      else $error("band write without a preceding read");

   a_page_range: assert property (@(posedge clock) disable iff (reset)
      page_cnt_ff <= PAGES_C)
      else $error("page counter beyond page count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("stalled chunk overwritten");

   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && chunk_ff == LAST_ROW) |=> (state_ff == ST_IDLE))
      else $error("flush did not end after the last chunk");

endmodule

// ===== test/paged_band_line_plotter_unit_test.sv =====
`timescale 1ns / 1ps
module paged_band_line_plotter_unit_test;
   import pbl_pkg::*;

   localparam int RUN_LIMIT_CYCLES = 12_000_000;
   localparam int IDLE_PERCENT     = 15;
   localparam int SCREEN_HEIGHT    = SCREEN_HEIGHT_DEF;
   localparam int PAGE_COUNT       = PAGE_COUNT_DEF;
   localparam int CHUNK_COUNT      = BAND_COLS / COLS_PER_ROW;
   localparam int RANDOM_FRAMES    = 11;
   localparam logic [1:0] COLOR_KEEP = 2'd3;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [1:0] csr_wdata = ROT_0;

   // predicted display state
   logic [7:0] band_image [BAND_COLS];
   logic [3:0] page_mirror;
   logic [1:0] rotation_mirror;
   rsp_type    expected_chunks [$];
   int         settle_cycles = 0;
   int         fail_count = 0;
   int         cycle_count = 0;
   bit         no_idle = 1'b0;

   paged_band_line_plotter_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int magnitude(int v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic int pick_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic void clear_band_image();
      foreach (band_image[c]) band_image[c] = 8'h00;
   endfunction

   function automatic void plot_expected_pixel(int x, int y, logic [1:0] color);
      int w, h, px, py;
      logic [7:0] mask;
      w = rotation_mirror[0] ? SCREEN_HEIGHT : SCREEN_WIDTH;
      h = rotation_mirror[0] ? SCREEN_WIDTH : SCREEN_HEIGHT;
      if (x < 0 || x >= w || y < 0 || y >= h) return;
      case (rotation_mirror)
         ROT_90: begin
            px = SCREEN_WIDTH - 1 - y;
            py = x;
         end
         ROT_180: begin
            px = SCREEN_WIDTH - 1 - x;
            py = SCREEN_HEIGHT - 1 - y;
         end
         ROT_270: begin
            px = y;
            py = SCREEN_HEIGHT - 1 - x;
         end
         default: begin
            px = x;
            py = y;
         end
      endcase
      if (px < 0 || px >= BAND_COLS || py < 0) return;
      if (py / 8 != int'(page_mirror)) return;
      mask = 8'd1 << (py % 8);
      case (color)
         COLOR_CLEAR:  band_image[px] = band_image[px] & ~mask;
         COLOR_SET:    band_image[px] = band_image[px] | mask;
         COLOR_INVERT: band_image[px] = band_image[px] ^ mask;
         default: ;
      endcase
   endfunction

   // Bresenham walk along the major axis; returns the number of steps
   function automatic int trace_expected_line(int x0, int y0, int x1, int y1,
                                              logic [1:0] color);
      int t, dx, dy, err, ystep, steps;
      bit steep;
      steep = magnitude(y1 - y0) > magnitude(x1 - x0);
      if (steep) begin
         t = x0; x0 = y0; y0 = t;
         t = x1; x1 = y1; y1 = t;
      end
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      dx = x1 - x0;
      dy = magnitude(y1 - y0);
      err = dx / 2;
      ystep = (y0 < y1) ? 1 : -1;
      steps = dx + 1;
      while (x0 <= x1) begin
         if (steep) plot_expected_pixel(y0, x0, color);
         else plot_expected_pixel(x0, y0, color);
         err -= dy;
         if (err < 0) begin
            y0 += ystep;
            err += dx;
         end
         x0++;
      end
      return steps;
   endfunction

   function automatic void emit_expected_flush();
      rsp_type    chunk;
      logic [2:0] page;
      logic       done;
      page = page_mirror[2:0];
      if (int'(page_mirror) < PAGE_COUNT) page_mirror++;
      done = int'(page_mirror) >= PAGE_COUNT;
      for (int k = 0; k < CHUNK_COUNT; k++) begin
         chunk.page_number = page;
         chunk.chunk_index = k[ROW_W-1:0];
         chunk.chunk_bytes = {band_image[4*k+3], band_image[4*k+2],
                              band_image[4*k+1], band_image[4*k]};
         chunk.last_chunk  = (k == CHUNK_COUNT - 1);
         chunk.frame_done  = done;
         expected_chunks.push_back(chunk);
      end
      if (!done) clear_band_image();
   endfunction

   // apply one command; returns cycles the block may still need afterwards
   function automatic int update_display_model(req_type item);
      int xs, ys, xe, ye, settle;
      xs = $signed(item.x_start);
      ys = $signed(item.y_start);
      xe = $signed(item.x_end);
      ye = $signed(item.y_end);
      settle = 4;
      case (item.cmd)
         CMD_START: begin
            clear_band_image();
            page_mirror = '0;
         end
         CMD_PIXEL: begin
            plot_expected_pixel(xs, ys, item.color);
            settle = 8;
         end
         CMD_LINE: settle = 2 * trace_expected_line(xs, ys, xe, ye, item.color) + 8;
         default: emit_expected_flush();
      endcase
      return settle;
   endfunction

   function automatic req_type make_req(cmd_type op, int xs, int ys, int xe, int ye,
                                        logic [1:0] color);
      req_type r;
      r.cmd     = op;
      r.x_start = xs[IN_COORD_W-1:0];
      r.y_start = ys[IN_COORD_W-1:0];
      r.x_end   = xe[IN_COORD_W-1:0];
      r.y_end   = ye[IN_COORD_W-1:0];
      r.color   = color;
      return r;
   endfunction

   function automatic req_type random_req(cmd_type op);
      return make_req(op, pick_between(-2048, 2047), pick_between(-2048, 2047),
                      pick_between(-2048, 2047), pick_between(-2048, 2047),
                      2'($urandom_range(3)));
   endfunction

   function automatic logic [1:0] random_color();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) return COLOR_SET;
      if (sel < 6) return COLOR_CLEAR;
      if (sel < 9) return COLOR_INVERT;
      return COLOR_KEEP;
   endfunction

   function automatic int line_coord(int span);
      int sel;
      sel = $urandom_range(99);
      if (sel < 85) return pick_between(-20, span + 20);
      if (sel < 95) return pick_between(-300, 400);
      return pick_between(-2048, 2047);
   endfunction

   // mostly aim at the current page by mapping a physical spot back to logical
   function automatic req_type random_pixel(logic [1:0] color);
      int px, py, x, y, w, h;
      w = rotation_mirror[0] ? SCREEN_HEIGHT : SCREEN_WIDTH;
      h = rotation_mirror[0] ? SCREEN_WIDTH : SCREEN_HEIGHT;
      if ($urandom_range(99) < 60) begin
         px = pick_between(-2, BAND_COLS + 1);
         py = 8 * int'(page_mirror[2:0]) + int'($urandom_range(7));
         case (rotation_mirror)
            ROT_90: begin
               x = py;
               y = SCREEN_WIDTH - 1 - px;
            end
            ROT_180: begin
               x = SCREEN_WIDTH - 1 - px;
               y = SCREEN_HEIGHT - 1 - py;
            end
            ROT_270: begin
               x = SCREEN_HEIGHT - 1 - py;
               y = px;
            end
            default: begin
               x = px;
               y = py;
            end
         endcase
      end else if ($urandom_range(99) < 80) begin
         x = pick_between(-4, w + 3);
         y = pick_between(-4, h + 3);
      end else begin
         x = pick_between(-2048, 2047);
         y = pick_between(-2048, 2047);
      end
      return make_req(CMD_PIXEL, x, y, pick_between(-2048, 2047),
                      pick_between(-2048, 2047), color);
   endfunction

   task automatic send_command(req_type item);
      int gap;
      logic [63:0] noise;
      gap = (no_idle || $urandom_range(99) >= IDLE_PERCENT) ? 0 : $urandom_range(1, 4);
      @(negedge clock);
      if (gap > 0) begin
         noise     = {$urandom, $urandom};
         req_valid = 1'b0;
         req_data  = noise[$bits(req_type)-1:0];
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      settle_cycles = update_display_model(item);
   endtask

   // hold the sender until every chunk is back and the last command has settled
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_chunks.size() != 0) @(negedge clock);
      repeat (settle_cycles) @(negedge clock);
   endtask

   task automatic write_rotation(logic [1:0] turns);
      hold_until_drained();
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = turns;
      @(negedge clock);
      csr_we    = 1'b0;
      rotation_mirror = turns;
   endtask

   task automatic test_flush_after_reset();
      send_command(make_req(CMD_FLUSH, 0, 0, 0, 0, COLOR_CLEAR));
      hold_until_drained();
   endtask

   task automatic test_single_pixels();
      send_command(make_req(CMD_START, 0, 0, 0, 0, COLOR_SET));
      send_command(make_req(CMD_PIXEL, 0, 0, 0, 0, COLOR_SET));
      send_command(make_req(CMD_PIXEL, 127, 7, 0, 0, COLOR_SET));
      send_command(make_req(CMD_PIXEL, 127, 7, 0, 0, COLOR_INVERT));
      send_command(make_req(CMD_PIXEL, 5, 3, 0, 0, COLOR_INVERT));
      send_command(make_req(CMD_PIXEL, 5, 3, 0, 0, COLOR_KEEP));
      send_command(make_req(CMD_PIXEL, 5, 3, 0, 0, COLOR_CLEAR));
      // off screen and off page: dropped
      send_command(make_req(CMD_PIXEL, -1, 0, 0, 0, COLOR_SET));
      send_command(make_req(CMD_PIXEL, 2047, -2048, -2048, 2047, COLOR_SET));
      send_command(make_req(CMD_PIXEL, 10, 8, 0, 0, COLOR_SET));
      send_command(make_req(CMD_FLUSH, 0, 0, 0, 0, COLOR_SET));
      hold_until_drained();
   endtask

   task automatic test_line_shapes();
      send_command(make_req(CMD_START, 0, 0, 0, 0, COLOR_SET));
      send_command(make_req(CMD_LINE, 0, 0, 127, 7, COLOR_SET));
      send_command(make_req(CMD_LINE, 3, 0, 6, 63, COLOR_INVERT));
      send_command(make_req(CMD_LINE, 100, 5, 20, 1, COLOR_SET));
      send_command(make_req(CMD_LINE, 50, 4, 50, 4, COLOR_INVERT));
      send_command(make_req(CMD_LINE, -2048, 2047, 2047, -2048, COLOR_SET));
      send_command(make_req(CMD_LINE, 0, 2, 127, 2, COLOR_CLEAR));
      send_command(make_req(CMD_FLUSH, 0, 0, 0, 0, COLOR_SET));
      hold_until_drained();
   endtask

   task automatic send_random_draw();
      int w, h, sel;
      w = rotation_mirror[0] ? SCREEN_HEIGHT : SCREEN_WIDTH;
      h = rotation_mirror[0] ? SCREEN_WIDTH : SCREEN_HEIGHT;
      sel = $urandom_range(99);
      if (sel < 5)
         send_command(random_req(cmd_type'($urandom_range(3))));
      else if (sel < 50)
         send_command(random_pixel(random_color()));
      else
         send_command(make_req(CMD_LINE, line_coord(w), line_coord(h),
                               line_coord(w), line_coord(h), random_color()));
   endtask

   // one picture per page, sometimes flushed again after the frame is done
   task automatic draw_random_frame();
      send_command(random_req(CMD_START));
      repeat (PAGE_COUNT + (($urandom_range(2) == 0) ? 1 : 0)) begin
         repeat ($urandom_range(1, 4)) send_random_draw();
         send_command(random_req(CMD_FLUSH));
      end
   endtask

   task automatic test_random_frames();
      for (int f = 0; f < RANDOM_FRAMES; f++) begin
         write_rotation((f < 4) ? f[1:0] : 2'($urandom_range(3)));
         no_idle = (f == 5);
         draw_random_frame();
      end
      no_idle = 1'b0;
   endtask

   function automatic void report_if_differs(string field, logic [31:0] want,
                                             logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_chunks.size() == 0) begin
            $display("%0t: chunk transaction with none expected: %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = expected_chunks.pop_front();
            report_if_differs("page_number", 32'(want.page_number),
                              32'(rsp_data.page_number));
            report_if_differs("chunk_index", 32'(want.chunk_index),
                              32'(rsp_data.chunk_index));
            report_if_differs("chunk_bytes", want.chunk_bytes, rsp_data.chunk_bytes);
            report_if_differs("last_chunk", 32'(want.last_chunk),
                              32'(rsp_data.last_chunk));
            report_if_differs("frame_done", 32'(want.frame_done),
                              32'(rsp_data.frame_done));
         end
      end
   end

   always @(negedge clock)
      rsp_stall = !no_idle && ($urandom_range(99) < IDLE_PERCENT);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT_CYCLES) begin
         $display("FAIL paged_band_line_plotter_unit");
         $finish;
      end
   end

   initial begin
      clear_band_image();
      page_mirror     = '0;
      rotation_mirror = ROT_0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_flush_after_reset();
      test_single_pixels();
      test_line_shapes();
      test_random_frames();
      hold_until_drained();
      if (fail_count == 0)
         $display("PASS paged_band_line_plotter_unit");
      else
         $display("FAIL paged_band_line_plotter_unit");
      $finish;
   end

endmodule
